// File: rtl/core/ths_pkg.sv
// ----------------------------------------------------------------------------
// ths_pkg
// Shared types, codes and sizes for the text body height selector.
// ----------------------------------------------------------------------------
package ths_pkg;

   // Geometry and limits
   localparam int MAX_ROWS     = 1024;
   localparam int MAX_COLS     = 4096;
   localparam int MAX_SEGMENTS = 256;

   localparam int COL_W   = 12;
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
   localparam int CNT_W   = $clog2(MAX_SEGMENTS + 2);
   localparam int HSUM_W  = 18;
   localparam int LTOT_W  = 20;
   localparam int PROD_W  = ROW_W + COL_W;
   localparam int WSUM_W  = 31;
   localparam int QUO_W   = WSUM_W;
   localparam int DVS_W   = LTOT_W;
   localparam int DIV_STEPS   = QUO_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   // Histogram and window scan
   localparam int HIST_W      = 9;
   localparam int HIST_SAT    = (1 << HIST_W) - 1;
   localparam int WIN_BEFORE  = 5;
   localparam int WIN_AFTER   = 4;
   localparam int WIN_LEN     = WIN_BEFORE + WIN_AFTER + 1;
   localparam int WIN_SUM_W   = $clog2(WIN_LEN * HIST_SAT + 1);
   localparam int SWEEP_END   = MAX_ROWS + WIN_AFTER;
   localparam int SWEEP_W     = $clog2(SWEEP_END + 1);

   localparam int MEAN_BONUS  = 5;

   // Configuration and result fields
   localparam int MODE_W      = 3;
   localparam int IMG_W       = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_IDX_W   = 1;
   localparam int HEIGHT_W    = 11;
   localparam int STS_W       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NORM_MODE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS = 1'b1;

   localparam logic [MODE_W-1:0] MODE_WMEAN      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MAX        = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SECOND     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MEAN_BONUS = 3'd4;
   localparam logic [MODE_W-1:0] MODE_MEAN       = 3'd5;
   localparam logic [MODE_W-1:0] MODE_WINDOW     = 3'd6;

   localparam logic [MODE_W-1:0] RESET_MODE = MODE_MEAN;
   localparam logic [IMG_W-1:0]  RESET_ROWS = 11'd256;

   localparam logic [STS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STS_W-1:0] STS_NO_LENGTH = 2'd1;
   localparam logic [STS_W-1:0] STS_BAD_MODE  = 2'd2;
   localparam logic [STS_W-1:0] STS_OVERFLOW  = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_FINISH,
      ST_DIV,
      ST_SWEEP,
      ST_DONE
   } ths_state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic commit;
      logic finish;
      logic div_start;
      logic sweep_run;
      logic load_out;
   } ths_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last;
      logic need_div;
      logic div_busy;
      logic sweep_done;
      logic out_free;
   } ths_sts_type;

endpackage

// File: rtl/core/text_body_height_selector.sv
// ----------------------------------------------------------------------------
// text_body_height_selector
// Accumulates text segments of a line and returns one body height per line.
// ----------------------------------------------------------------------------
// Each request is captured, with its histogram row read, and then committed:
// the statistics are updated and the row is written back through the write
// port of the histogram memory, which has separate read and write ports. The
// request marked last then goes through status decode, a division in modes
// 1, 4 and 5 when the status is OK (one quotient bit per cycle), and a sweep
// that reads and zeroes all 1024 histogram rows while scanning the window
// sums for mode 6; the result is then loaded into the output register, and
// the next request is taken while it waits. After reset the sweep clears the
// histogram with req_stall high; configuration writes are taken at any time.
module text_body_height_selector
   import ths_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COL_W-1:0]      req_seg_start,
   input  logic [COL_W-1:0]      req_seg_end,
   input  logic [ROW_W-1:0]      req_upper_row,
   input  logic [ROW_W-1:0]      req_lower_row,
   input  logic                  req_is_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [HEIGHT_W-1:0]   rsp_norm_height,
   output logic [STS_W-1:0]      rsp_status
);

   ths_cmd_type cmd;
   ths_sts_type sts;

   ths_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ths_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_seg_start   (req_seg_start),
      .req_seg_end     (req_seg_end),
      .req_upper_row   (req_upper_row),
      .req_lower_row   (req_lower_row),
      .req_is_last     (req_is_last),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_norm_height (rsp_norm_height),
      .rsp_status      (rsp_status)
   );

endmodule

// File: rtl/core/ths_div.sv
// ----------------------------------------------------------------------------
// ths_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ths_div
   import ths_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [QUO_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [QUO_W-1:0] quotient,
   output logic             busy
);

   logic [QUO_W-1:0]     quot_ff, quot_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic [DVS_W:0]       trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quot_ff[QUO_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      quot_in = {quot_ff[QUO_W-2:0], fits};
      rem_in  = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign quotient = quot_ff;
   assign busy     = busy_ff;

endmodule

// File: rtl/core/ths_dp.sv
// ----------------------------------------------------------------------------
// ths_dp
// Datapath: configuration registers, line statistics, row histogram with
// its clear and window scan, divider and result register.
// ----------------------------------------------------------------------------
module ths_dp
   import ths_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ths_cmd_type           cmd,
   output ths_sts_type           sts,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic [COL_W-1:0]      req_seg_start,
   input  logic [COL_W-1:0]      req_seg_end,
   input  logic [ROW_W-1:0]      req_upper_row,
   input  logic [ROW_W-1:0]      req_lower_row,
   input  logic                  req_is_last,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [HEIGHT_W-1:0]   rsp_norm_height,
   output logic [STS_W-1:0]      rsp_status
);

   // Configuration
   logic [MODE_W-1:0] norm_mode_ff;
   logic [IMG_W-1:0]  image_rows_ff;

   // Captured request
   logic [ROW_W-1:0]  h_ff;
   logic [COL_W-1:0]  len_ff;
   logic [ROW_W-1:0]  idx_ff;
   logic              acc_en_ff;
   logic              hist_en_ff;
   logic              last_ff;

   // Line statistics
   logic [CNT_W-1:0]  seg_cnt_ff;
   logic [HSUM_W-1:0] height_sum_ff;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [LTOT_W-1:0] len_tot_ff;
   logic [ROW_W-1:0]  tallest_ff;
   logic [ROW_W-1:0]  second_ff;

   // Line end
   logic [MODE_W-1:0] mode_ff;
   logic [ROWS_W-1:0] rows_ff;
   logic [STS_W-1:0]  status_ff;

   // Histogram memory
   logic [HIST_W-1:0] hist_mem [MAX_ROWS];
   logic [HIST_W-1:0] hist_rd_ff;
   logic [ROW_W-1:0]  rd_addr;
   logic [ROW_W-1:0]  wr_addr;
   logic [HIST_W-1:0] wr_data;
   logic              hist_we;

   // Sweep and window scan
   logic [SWEEP_W-1:0]   sweep_cnt_ff;
   logic                 proc_vld_ff;
   logic [SWEEP_W-1:0]   proc_k_ff;
   logic [HIST_W-1:0]    win_ff [WIN_LEN];
   logic [WIN_SUM_W-1:0] win_sum_ff, win_sum_in;
   logic [WIN_SUM_W-1:0] best_val_ff;
   logic [ROW_W-1:0]     best_row_ff;
   logic [HIST_W-1:0]    scan_val;
   logic                 row_in_range;

   // Result register
   logic                rsp_valid_ff;
   logic [HEIGHT_W-1:0] rsp_height_ff;
   logic [STS_W-1:0]    rsp_status_ff;

   // Request decode and line-end decisions
   logic [ROW_W-1:0]    h_c;
   logic [COL_W-1:0]    len_c;
   logic [ROWS_W-1:0]   rows_c;
   logic [IMG_W-1:0]    idx_c;
   logic                acc_ok_c;
   logic                hist_ok_c;
   logic [PROD_W-1:0]   prod_c;
   logic [STS_W-1:0]    status_c;
   logic                div_mode_c;
   logic [QUO_W-1:0]    dividend_c;
   logic [DVS_W-1:0]    divisor_c;
   logic [QUO_W-1:0]    quotient;
   logic                div_busy;
   logic [HEIGHT_W-1:0] result_c;

   always_comb begin
      h_c      = (req_lower_row > req_upper_row) ? req_lower_row - req_upper_row : '0;
      len_c    = (req_seg_end > req_seg_start) ? req_seg_end - req_seg_start : '0;
      rows_c   = (image_rows_ff > IMG_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                                                     : ROWS_W'(image_rows_ff);
      idx_c    = image_rows_ff - {1'b0, h_c};
      acc_ok_c = seg_cnt_ff < CNT_W'(MAX_SEGMENTS);
      hist_ok_c = acc_ok_c && ({1'b0, h_c} <= image_rows_ff)
                  && (ROWS_W'(idx_c) < rows_c);
      prod_c   = h_ff * len_ff;
      wsum_in  = wsum_ff + WSUM_W'(prod_c);
   end

   // Status and divider operands, from the statistics after the last commit
   always_comb begin
      div_mode_c = 1'b0;
      if (seg_cnt_ff > CNT_W'(MAX_SEGMENTS)) begin
         status_c = STS_OVERFLOW;
      end else begin
         unique case (norm_mode_ff)
            MODE_WMEAN:  status_c = (len_tot_ff == '0) ? STS_NO_LENGTH : STS_OK;
            MODE_MAX, MODE_SECOND, MODE_MEAN_BONUS, MODE_MEAN, MODE_WINDOW:
               status_c = STS_OK;
            default:     status_c = STS_BAD_MODE;
         endcase
      end
      unique case (norm_mode_ff)
         MODE_WMEAN, MODE_MEAN_BONUS, MODE_MEAN: div_mode_c = 1'b1;
         default:                                div_mode_c = 1'b0;
      endcase
      if (norm_mode_ff == MODE_WMEAN) begin
         dividend_c = wsum_ff;
         divisor_c  = len_tot_ff;
      end else begin
         dividend_c = QUO_W'(height_sum_ff);
         divisor_c  = DVS_W'(seg_cnt_ff);
      end
   end

   ths_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend_c),
      .divisor  (divisor_c),
      .quotient (quotient),
      .busy     (div_busy)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         norm_mode_ff  <= RESET_MODE;
         image_rows_ff <= RESET_ROWS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NORM_MODE:  norm_mode_ff  <= csr_wr_data[MODE_W-1:0];
            CSR_IMAGE_ROWS: image_rows_ff <= csr_wr_data[IMG_W-1:0];
            default:        ;
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         h_ff       <= h_c;
         len_ff     <= len_c;
         idx_ff     <= idx_c[ROW_W-1:0];
         acc_en_ff  <= acc_ok_c;
         hist_en_ff <= hist_ok_c;
         last_ff    <= req_is_last;
      end
   end

   // Line statistics: clear once the result is loaded
   always_ff @(posedge clock) begin
      if (reset || cmd.load_out) begin
         seg_cnt_ff    <= '0;
         height_sum_ff <= '0;
         wsum_ff       <= '0;
         len_tot_ff    <= '0;
         tallest_ff    <= '0;
         second_ff     <= '0;
      end else if (cmd.commit) begin
         if (acc_en_ff) begin
            seg_cnt_ff    <= seg_cnt_ff + 1'b1;
            height_sum_ff <= height_sum_ff + HSUM_W'(h_ff);
            wsum_ff       <= wsum_in;
            len_tot_ff    <= len_tot_ff + LTOT_W'(len_ff);
            if (h_ff > tallest_ff) begin
               second_ff  <= tallest_ff;
               tallest_ff <= h_ff;
            end else if (h_ff < tallest_ff && h_ff > second_ff) begin
               second_ff <= h_ff;
            end
         end else begin
            seg_cnt_ff <= CNT_W'(MAX_SEGMENTS + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         mode_ff   <= norm_mode_ff;
         rows_ff   <= rows_c;
         status_ff <= status_c;
      end
   end

   // Histogram port steering: the sweep reads and zeroes each row in turn
   always_comb begin
      rd_addr = cmd.sweep_run ? sweep_cnt_ff[ROW_W-1:0] : idx_c[ROW_W-1:0];
      if (cmd.sweep_run) begin
         hist_we = sweep_cnt_ff < SWEEP_W'(MAX_ROWS);
         wr_addr = sweep_cnt_ff[ROW_W-1:0];
         wr_data = '0;
      end else begin
         hist_we = cmd.commit && hist_en_ff && (hist_rd_ff != HIST_W'(HIST_SAT));
         wr_addr = idx_ff;
         wr_data = hist_rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      hist_rd_ff <= hist_mem[rd_addr];
      if (hist_we) begin
         hist_mem[wr_addr] <= wr_data;
      end
   end

   // Sweep counter
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         sweep_cnt_ff <= '0;
         proc_vld_ff  <= 1'b0;
      end else if (cmd.sweep_run) begin
         proc_vld_ff <= sweep_cnt_ff != SWEEP_W'(SWEEP_END);
         if (sweep_cnt_ff != SWEEP_W'(SWEEP_END)) begin
            sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
         end
      end else begin
         proc_vld_ff <= 1'b0;
      end
   end

   // Sliding window over the histogram; rows past the image read as zero
   always_comb begin
      scan_val     = (proc_k_ff < SWEEP_W'(rows_ff)) ? hist_rd_ff : '0;
      win_sum_in   = win_sum_ff + WIN_SUM_W'(scan_val) - WIN_SUM_W'(win_ff[WIN_LEN-1]);
      row_in_range = (proc_k_ff >= SWEEP_W'(WIN_AFTER))
                     && ({1'b0, proc_k_ff} < ({1'b0, SWEEP_W'(rows_ff)}
                                               + (SWEEP_W+1)'(WIN_AFTER)));
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_run) begin
         proc_k_ff <= sweep_cnt_ff;
      end
      if (cmd.finish) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            win_ff[i] <= '0;
         end
         win_sum_ff  <= '0;
         best_val_ff <= '0;
         best_row_ff <= '0;
      end else if (proc_vld_ff) begin
         win_ff[0] <= scan_val;
         for (int i = 1; i < WIN_LEN; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
         win_sum_ff <= win_sum_in;
         // strict compare keeps the first row with the largest sum
         if (row_in_range && win_sum_in > best_val_ff) begin
            best_val_ff <= win_sum_in;
            best_row_ff <= ROW_W'(proc_k_ff - SWEEP_W'(WIN_AFTER));
         end
      end
   end

   // Result selection
   always_comb begin
      result_c = '0;
      if (status_ff == STS_OK) begin
         unique case (mode_ff)
            MODE_WMEAN, MODE_MEAN: result_c = quotient[HEIGHT_W-1:0];
            MODE_MEAN_BONUS: result_c = quotient[HEIGHT_W-1:0] + HEIGHT_W'(MEAN_BONUS);
            MODE_MAX:        result_c = HEIGHT_W'(tallest_ff);
            MODE_SECOND:     result_c = (second_ff != '0) ? HEIGHT_W'(second_ff)
                                                          : HEIGHT_W'(tallest_ff);
            MODE_WINDOW:     result_c = HEIGHT_W'(rows_ff) - HEIGHT_W'(best_row_ff);
            default:         result_c = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_height_ff <= result_c;
         rsp_status_ff <= status_ff;
      end
   end

   always_comb begin
      sts.last       = last_ff;
      sts.need_div   = (status_c == STS_OK) && div_mode_c;
      sts.div_busy   = div_busy;
      sts.sweep_done = sweep_cnt_ff == SWEEP_W'(SWEEP_END);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_norm_height = rsp_height_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// File: rtl/core/ths_ctrl.sv
// ----------------------------------------------------------------------------
// ths_ctrl
// Sequencer: request intake, line-end division, histogram sweep, result load.
// ----------------------------------------------------------------------------
module ths_ctrl
   import ths_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ths_sts_type sts,
   output ths_cmd_type cmd
);

   ths_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_run = 1'b1;
            if (sts.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.commit = 1'b1;
            state_in   = sts.last ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_SWEEP;
            end
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.sweep_run = 1'b1;
            if (sts.sweep_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

// File: rtl/core/ths_chk.sv
// ----------------------------------------------------------------------------
// ths_chk
// Port-level checks for the text body height selector, bound to the top.
// ----------------------------------------------------------------------------
module ths_chk
   import ths_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [COL_W-1:0]      req_seg_start,
   input  logic [COL_W-1:0]      req_seg_end,
   input  logic [ROW_W-1:0]      req_upper_row,
   input  logic [ROW_W-1:0]      req_lower_row,
   input  logic                  req_is_last,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [HEIGHT_W-1:0]   rsp_norm_height,
   input  logic [STS_W-1:0]      rsp_status
);

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An error status carries a zero height
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |-> rsp_norm_height == '0)
      else $error("nonzero height with error status");

   // Heights never exceed the largest row index plus the mean bonus
   a_height_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_norm_height <= HEIGHT_W'(MAX_ROWS - 1 + MEAN_BONUS))
      else $error("height out of range");

   // Every request is followed by its update cycle
   a_req_update: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on consecutive cycles");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_norm_height)
                                 && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind text_body_height_selector ths_chk u_ths_chk (.*);
